// ----- rtl/cjd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the calendar / Julian day converter.
// No dependencies; imported by every module of the block.
package cjd_pkg;

	localparam int STAGES    = 8;
	localparam int FRAC_BITS = 32;

	localparam logic [22:0] EPOCH     = 23'd1721120;
	localparam logic [23:0] FIRST_DAY = 24'd1721427;
	localparam logic [23:0] LAST_DAY  = 24'd5373485;
	localparam logic [22:0] NEG_365   = 23'h7FFE93;

	localparam logic [63:0] FRAC_ONE   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] HALF_SEC_W = (FRAC_ONE + 64'd86400) / 64'd172800;
	localparam logic [31:0] HALF_SEC   = HALF_SEC_W[31:0];

	// ceil(2^k / d) reciprocals; exact for the operand ranges used
	localparam logic [63:0] R675_W    = ((64'd1 << 28) + 64'd674) / 64'd675;
	localparam logic [63:0] R100_W    = ((64'd1 << 21) + 64'd99) / 64'd100;
	localparam logic [63:0] R146097_W = ((64'd1 << 42) + 64'd146096) / 64'd146097;
	localparam logic [63:0] R1461_W   = ((64'd1 << 30) + 64'd1460) / 64'd1461;
	localparam logic [63:0] R153_W    = ((64'd1 << 20) + 64'd152) / 64'd153;
	localparam logic [63:0] R5_W      = ((64'd1 << 12) + 64'd4) / 64'd5;

	localparam logic [18:0] R675    = R675_W[18:0];
	localparam logic [14:0] R100    = R100_W[14:0];
	localparam logic [24:0] R146097 = R146097_W[24:0];
	localparam logic [19:0] R1461   = R1461_W[19:0];
	localparam logic [12:0] R153    = R153_W[12:0];
	localparam logic [9:0]  R5      = R5_W[9:0];

	typedef struct packed {
		logic [22:0] day_number;
		logic [31:0] day_fraction;
	} fwd_res_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        range_error;
	} inv_res_t;

	// (153 * tm + 2) / 5, days before shifted month tm (March = 0)
	function automatic logic [8:0] month_offset(input logic [3:0] tm);
		logic [8:0] r;
		unique case (tm)
			4'd0:  r = 9'd0;
			4'd1:  r = 9'd31;
			4'd2:  r = 9'd61;
			4'd3:  r = 9'd92;
			4'd4:  r = 9'd122;
			4'd5:  r = 9'd153;
			4'd6:  r = 9'd184;
			4'd7:  r = 9'd214;
			4'd8:  r = 9'd245;
			4'd9:  r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			4'd12: r = 9'd367;
			4'd13: r = 9'd398;
			4'd14: r = 9'd428;
			4'd15: r = 9'd459;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/calendar_julian_day_converter.sv -----
`timescale 1ns / 1ps
// Top level: stream ports, pipeline valid/stall control and result select.
// Uses cjd_pkg, cjd_fwd and cjd_inv.
//
// Converts a calendar date and time to a day number plus Q0.32 day fraction
// (tuser = 0), or a day stamp back to date and time (tuser = 1). Every input
// item gives exactly one result item; fields of the unused direction are zero.
// The depth is set by the eight-stage inverse datapath (reciprocal
// multiplies spread over the stages); the forward path is padded with
// delay stages to the same depth. Throughput is one item per clock while
// m_tready is high. Each stage holds its own valid bit and
// advances when the stage after it is empty or advancing, so bubbles are
// squeezed out and s_tready stays high while any stage is free.
// When m_tready is low the last stage holds its item and stages fill up
// behind it; nothing is dropped or repeated.
// arst_n clears all valid bits; data registers are not reset.
module calendar_julian_day_converter import cjd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// in_year, in_month, in_day, in_hour, in_minute, in_second,
	// in_day_number, in_day_fraction, one zero pad bit
	input  logic [95:0] s_tdata,
	// func
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_day_number, out_day_fraction, out_year, out_month, out_day,
	// out_hour, out_minute, out_second, range_error
	output logic [95:0] m_tdata
);

	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] func_q;
	logic [STAGES-1:0] en;
	fwd_res_t          fwd_res;
	inv_res_t          inv_res;
	fwd_res_t          fwd_out;
	inv_res_t          inv_out;

	always_comb begin
		en[STAGES-1] = !vld_q[STAGES-1] || m_tready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			func_q[0] <= s_tuser[0];
		end
		for (int k = 1; k < STAGES; k++) begin
			if (en[k]) begin
				func_q[k] <= func_q[k-1];
			end
		end
	end

	cjd_fwd u_fwd (
		.clk       (clk),
		.en        (en),
		.in_year   (s_tdata[13:0]),
		.in_month  (s_tdata[17:14]),
		.in_day    (s_tdata[22:18]),
		.in_hour   (s_tdata[27:23]),
		.in_minute (s_tdata[33:28]),
		.in_second (s_tdata[39:34]),
		.res       (fwd_res)
	);

	cjd_inv u_inv (
		.clk             (clk),
		.en              (en),
		.in_day_number   (s_tdata[62:40]),
		.in_day_fraction (s_tdata[94:63]),
		.res             (inv_res)
	);

	assign fwd_out = func_q[STAGES-1] ? '0 : fwd_res;
	assign inv_out = func_q[STAGES-1] ? inv_res : '0;

	assign m_tvalid = vld_q[STAGES-1];
	assign m_tdata  = {inv_out.range_error, inv_out.second, inv_out.minute, inv_out.hour,
		inv_out.day, inv_out.month, inv_out.year, fwd_out.day_fraction, fwd_out.day_number};

endmodule

// ----- rtl/cjd_fwd.sv -----
`timescale 1ns / 1ps
// Forward datapath: calendar date and time to day number and Q0.32 fraction.
// Eight register stages, advanced by the per-stage enables; uses cjd_pkg.
module cjd_fwd import cjd_pkg::*; (
	input  logic              clk,
	input  logic [STAGES-1:0] en,
	input  logic [13:0]       in_year,
	input  logic [3:0]        in_month,
	input  logic [4:0]        in_day,
	input  logic [4:0]        in_hour,
	input  logic [5:0]        in_minute,
	input  logic [5:0]        in_second,
	output fwd_res_t          res
);

	logic [16:0] secs, secs_mod;
	logic        roll, early;
	logic [13:0] ty;
	logic [3:0]  tm;

	logic [16:0] secs_s1, secs_s2;
	logic        roll_s1, roll_s2, roll_s3;
	logic [13:0] ty_s1, ty_s2;
	logic [3:0]  tm_s1, tm_s2, tm_s3;
	logic        neg_s1, neg_s2, neg_s3;
	logic [4:0]  day_s1, day_s2, day_s3;

	logic [35:0] prod_u, prod_t;
	logic [28:0] prod_c;
	logic [6:0]  u_s2, u_s3, u_s4, u_s5;
	logic [7:0]  c_s2;

	logic [25:0] prod_t1;
	logic [9:0]  v_s3;
	logic [6:0]  r_s3;
	logic [22:0] t1_s3;

	logic [17:0] prod_r;
	logic [16:0] w_s4;
	logic [24:0] q2a_s4, q2a_s5;
	logic [22:0] t2_s4, jda_s4;

	logic [7:0]  t_s5;
	logic [22:0] jd_s5, jd_s6, jd_s7, jd_s8;
	logic [31:0] frac_s6, frac_s7, frac_s8;

	always_comb begin
		secs = 17'(in_hour) * 17'd3600 + 17'(in_minute) * 17'd60 + 17'(in_second);
		// at most one whole day fits in the time fields
		roll = secs >= 17'd86400;
		secs_mod = roll ? secs - 17'd86400 : secs;
		early = in_month <= 4'd2;
		ty = early ? in_year - 14'd1 : in_year;
		tm = early ? in_month + 4'd9 : in_month - 4'd3;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			secs_s1 <= secs_mod;
			roll_s1 <= roll;
			ty_s1   <= ty;
			tm_s1   <= tm;
			neg_s1  <= early && (in_year == 14'd0);
			day_s1  <= in_day;
		end
	end

	assign prod_u = 36'(secs_s1) * 36'(R675);
	assign prod_c = 29'(ty_s1) * 29'(R100);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			secs_s2 <= secs_s1;
			u_s2    <= prod_u[34:28];
			c_s2    <= prod_c[28:21];
			ty_s2   <= ty_s1;
			tm_s2   <= tm_s1;
			neg_s2  <= neg_s1;
			day_s2  <= day_s1;
			roll_s2 <= roll_s1;
		end
	end

	assign prod_t1 = 26'(c_s2) * 26'd146097;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			v_s3    <= 10'(secs_s2 - 17'(u_s2) * 17'd675);
			r_s3    <= 7'(ty_s2 - 14'(c_s2) * 14'd100);
			// shifted year -1 has a truncated century of zero
			t1_s3   <= neg_s2 ? 23'd0 : prod_t1[24:2];
			u_s3    <= u_s2;
			tm_s3   <= tm_s2;
			neg_s3  <= neg_s2;
			day_s3  <= day_s2;
			roll_s3 <= roll_s2;
		end
	end

	assign prod_r = 18'(r_s3) * 18'd1461;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			// 2^25 = 675 * 49710 + 182
			w_s4   <= 17'(v_s3) * 17'd182 + 17'd337;
			q2a_s4 <= 25'(v_s3) * 25'd49710;
			u_s4   <= u_s3;
			// shifted year -1 gives a truncated 1461 * -1 / 4
			t2_s4  <= neg_s3 ? NEG_365 : 23'(prod_r[17:2]);
			jda_s4 <= t1_s3 + 23'(month_offset(tm_s3)) + 23'(day_s3) + EPOCH + 23'(roll_s3);
		end
	end

	assign prod_t = 36'(w_s4) * 36'(R675);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			t_s5   <= prod_t[35:28];
			q2a_s5 <= q2a_s4;
			u_s5   <= u_s4;
			jd_s5  <= jda_s4 + t2_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			frac_s6 <= {u_s5, 25'd0} + 32'(q2a_s5) + 32'(t_s5);
			jd_s6   <= jd_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			frac_s7 <= frac_s6;
			jd_s7   <= jd_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			frac_s8 <= frac_s7;
			jd_s8   <= jd_s7;
		end
	end

	assign res.day_number   = jd_s8;
	assign res.day_fraction = frac_s8;

endmodule

// ----- rtl/cjd_inv.sv -----
`timescale 1ns / 1ps
// Inverse datapath: day number and Q0.32 fraction to calendar date and time.
// Eight register stages, advanced by the per-stage enables; uses cjd_pkg.
module cjd_inv import cjd_pkg::*; (
	input  logic              clk,
	input  logic [STAGES-1:0] en,
	input  logic [22:0]       in_day_number,
	input  logic [31:0]       in_day_fraction,
	output inv_res_t          res
);

	logic [32:0] fsum;
	logic [31:0] f_s1;
	logic [23:0] jd_s1;

	logic [23:0] j_full;
	logic [36:0] prod_h;
	logic [23:0] n1_s2, n1_s3;
	logic        err_s2, err_s3, err_s4, err_s5, err_s6, err_s7, err_s8;
	logic [4:0]  hr_s2, hr_s3, hr_s4, hr_s5, hr_s6, hr_s7, hr_s8;
	logic [31:0] fl_s2, fl_s3;

	logic [48:0] prod_cy;
	logic [37:0] prod_m, prod_s;
	logic [6:0]  cy_s3, cy_s4, cy_s5, cy_s6;
	logic [5:0]  mi_s3, mi_s4, mi_s5, mi_s6, mi_s7, mi_s8;
	logic [5:0]  se_s4, se_s5, se_s6, se_s7, se_s8;

	logic [17:0] j2;
	logic [17:0] n2_s4, n2_s5;
	logic [37:0] prod_yy;
	logic [6:0]  yy_s5, yy_s6;

	logic [10:0] rem1;
	logic [11:0] rem1_p;
	logic [10:0] n3_s6, n3_s7;
	logic [23:0] prod_mm;
	logic [3:0]  mm_s7;
	logic [13:0] yb_s7;

	logic [7:0]  rem2;
	logic [18:0] prod_d;
	logic        late;
	logic [13:0] year_s8;
	logic [3:0]  month_s8;
	logic [4:0]  day_s8;

	// half-second rounding, carry into the day number
	assign fsum = {1'b0, in_day_fraction} + {1'b0, HALF_SEC};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			f_s1  <= fsum[31:0];
			jd_s1 <= {1'b0, in_day_number} + 24'(fsum[32]);
		end
	end

	assign j_full = jd_s1 - 24'(EPOCH);
	assign prod_h = 37'(f_s1) * 37'd24;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			err_s2 <= (jd_s1 < FIRST_DAY) || (jd_s1 > LAST_DAY);
			n1_s2  <= {j_full[21:0], 2'b00} - 24'd1;
			hr_s2  <= prod_h[36:32];
			fl_s2  <= prod_h[31:0];
		end
	end

	assign prod_cy = 49'(n1_s2) * 49'(R146097);
	assign prod_m  = 38'(fl_s2) * 38'd60;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cy_s3  <= prod_cy[48:42];
			n1_s3  <= n1_s2;
			err_s3 <= err_s2;
			hr_s3  <= hr_s2;
			mi_s3  <= prod_m[37:32];
			fl_s3  <= prod_m[31:0];
		end
	end

	assign j2     = 18'(n1_s3 - 24'(cy_s3) * 24'd146097);
	assign prod_s = 38'(fl_s3) * 38'd60;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			n2_s4  <= {j2[17:2], 2'b11};
			cy_s4  <= cy_s3;
			err_s4 <= err_s3;
			hr_s4  <= hr_s3;
			mi_s4  <= mi_s3;
			se_s4  <= prod_s[37:32];
		end
	end

	assign prod_yy = 38'(n2_s4) * 38'(R1461);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			yy_s5  <= prod_yy[36:30];
			n2_s5  <= n2_s4;
			cy_s5  <= cy_s4;
			err_s5 <= err_s4;
			hr_s5  <= hr_s4;
			mi_s5  <= mi_s4;
			se_s5  <= se_s4;
		end
	end

	// day of the shifted year, then 5 * day - 3 for the month step
	assign rem1   = 11'(n2_s5 - 18'(yy_s5) * 18'd1461);
	assign rem1_p = 12'(rem1) + 12'd4;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			n3_s6  <= 11'(rem1_p[11:2]) * 11'd5 - 11'd3;
			yy_s6  <= yy_s5;
			cy_s6  <= cy_s5;
			err_s6 <= err_s5;
			hr_s6  <= hr_s5;
			mi_s6  <= mi_s5;
			se_s6  <= se_s5;
		end
	end

	assign prod_mm = 24'(n3_s6) * 24'(R153);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			mm_s7  <= prod_mm[23:20];
			n3_s7  <= n3_s6;
			yb_s7  <= 14'(cy_s6) * 14'd100 + 14'(yy_s6);
			err_s7 <= err_s6;
			hr_s7  <= hr_s6;
			mi_s7  <= mi_s6;
			se_s7  <= se_s6;
		end
	end

	assign rem2   = 8'(n3_s7 - 11'(mm_s7) * 11'd153);
	assign prod_d = (19'(rem2) + 19'd5) * 19'(R5);
	// January and February belong to the next calendar year
	assign late   = mm_s7 >= 4'd10;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			year_s8  <= yb_s7 + 14'(late);
			month_s8 <= late ? mm_s7 - 4'd9 : mm_s7 + 4'd3;
			day_s8   <= prod_d[16:12];
			err_s8   <= err_s7;
			hr_s8    <= hr_s7;
			mi_s8    <= mi_s7;
			se_s8    <= se_s7;
		end
	end

	assign res.year        = err_s8 ? 14'd0 : year_s8;
	assign res.month       = err_s8 ? 4'd0 : month_s8;
	assign res.day         = err_s8 ? 5'd0 : day_s8;
	assign res.hour        = hr_s8;
	assign res.minute      = mi_s8;
	assign res.second      = se_s8;
	assign res.range_error = err_s8;

endmodule
